### rtl/lbpm_pkg.sv
`default_nettype none

package lbpm_pkg;

	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 3;
	localparam int SLOT_IDX_W = 4;

	localparam logic [MODE_W-1:0] MODE_GET   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NEW   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLAGS = 2'd2;

	localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FILL    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REPLACE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_LOCKED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NONE    = 3'd4;

	// broadcast to every cell of the recency chain
	typedef struct packed {
		logic set_flags;
		logic dirty;
		logic lock;
	} cell_ctl_t;

endpackage

`default_nettype wire

### rtl/lbpm_cell.sv
`default_nettype none

// One position of the recency chain: holds the slot sitting there and its
// tag and flags. Loads from the neighbor ahead of it while the chain shifts back.
module lbpm_cell #(
	parameter int SLOT_W  = 4,
	parameter int ID_BITS = 20,
	parameter int POS     = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  ld,
	input  wire logic                  din_valid,
	input  wire logic [SLOT_W-1:0]     din_slot,
	input  wire logic [ID_BITS-1:0]    din_tag,
	input  wire logic                  din_dirty,
	input  wire logic                  din_lock,
	input  wire lbpm_pkg::cell_ctl_t   ctl,
	input  wire logic [SLOT_W-1:0]     flag_slot,
	output logic                       q_valid,
	output logic [SLOT_W-1:0]          q_slot,
	output logic [ID_BITS-1:0]         q_tag,
	output logic                       q_dirty,
	output logic                       q_lock
);

	logic                 valid_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [ID_BITS-1:0]   tag_q;
	logic                 dirty_q;
	logic                 lock_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			slot_q  <= SLOT_W'(POS);
			dirty_q <= 1'b0;
			lock_q  <= 1'b0;
		end else if (ld) begin
			valid_q <= din_valid;
			slot_q  <= din_slot;
			dirty_q <= din_dirty;
			lock_q  <= din_lock;
		end else if (ctl.set_flags && slot_q == flag_slot) begin
			dirty_q <= ctl.dirty;
			lock_q  <= ctl.lock;
		end
	end

	// tag only means something once valid is set
	always_ff @(posedge clk) begin
		if (ld) begin
			tag_q <= din_tag;
		end
	end

	assign q_valid = valid_q;
	assign q_slot  = slot_q;
	assign q_tag   = tag_q;
	assign q_dirty = dirty_q;
	assign q_lock  = lock_q;

endmodule

`default_nettype wire

### rtl/lru_buffer_pool_manager.sv
// Flow: a flag write, null or unused-mode word goes from accept to S_OUT and then to the
// output register; a get/create word first scans in S_SCAN, one recency position per cycle,
// then S_EVICT when a slot is evicted; S_OUT waits while the last result is still held.
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset: all slots empty and unlocked, recency order is slot index order, no result pending.
`default_nettype none

module lru_buffer_pool_manager #(
	parameter int SLOTS   = 16,
	parameter int ID_BITS = 20
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [lbpm_pkg::MODE_W-1:0]       mode,
	input  wire logic signed [ID_BITS:0]           block_id,
	input  wire logic [lbpm_pkg::SLOT_IDX_W-1:0]   slot,
	input  wire logic                              dirty_value,
	input  wire logic                              lock_value,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [lbpm_pkg::STATUS_W-1:0]          status,
	output logic [lbpm_pkg::SLOT_IDX_W-1:0]        slot_index,
	output logic                                   read_needed,
	output logic                                   write_back_needed,
	output logic [ID_BITS-1:0]                     write_back_block
);

	localparam int SLOT_W = $clog2(SLOTS);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EVICT, S_OUT} state_t;

	state_t                                state_q;
	logic [SLOT_W-1:0]                     cursor_q;
	logic [SLOT_W-1:0]                     vpos_q;
	logic                                  have_victim_q;
	logic [ID_BITS-1:0]                    req_id_q;
	logic                                  req_get_q;
	logic [lbpm_pkg::STATUS_W-1:0]         res_status_q;
	logic [lbpm_pkg::SLOT_IDX_W-1:0]       res_index_q;
	logic                                  res_rd_q;
	logic                                  res_wb_q;
	logic [ID_BITS-1:0]                    res_wb_block_q;
	logic                                  out_valid_q;
	logic [lbpm_pkg::STATUS_W-1:0]         out_status_q;
	logic [lbpm_pkg::SLOT_IDX_W-1:0]       out_index_q;
	logic                                  out_rd_q;
	logic                                  out_wb_q;
	logic [ID_BITS-1:0]                    out_wb_block_q;

	logic                  c_valid [SLOTS];
	logic [SLOT_W-1:0]     c_slot  [SLOTS];
	logic [ID_BITS-1:0]    c_tag   [SLOTS];
	logic                  c_dirty [SLOTS];
	logic                  c_lock  [SLOTS];

	logic                  accept;
	logic [SLOT_W-1:0]     pos;
	logic                  sel_valid;
	logic [SLOT_W-1:0]     sel_slot;
	logic [ID_BITS-1:0]    sel_tag;
	logic                  sel_dirty;
	logic                  sel_lock;
	logic                  hit;
	logic                  move;
	logic                  renew;
	logic                  f_valid;
	logic [ID_BITS-1:0]    f_tag;
	logic                  f_dirty;
	logic                  f_lock;
	logic                  slot_in_range;
	logic [SLOT_W-1:0]     flag_slot;
	lbpm_pkg::cell_ctl_t   ctl;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign pos       = (state_q == S_EVICT) ? vpos_q : cursor_q;
	assign sel_valid = c_valid[pos];
	assign sel_slot  = c_slot[pos];
	assign sel_tag   = c_tag[pos];
	assign sel_dirty = c_dirty[pos];
	assign sel_lock  = c_lock[pos];
	assign hit       = sel_valid && (sel_tag == req_id_q);

	// move: the selected position goes to the front this cycle
	// renew: it arrives there holding the requested block, flags clear
	always_comb begin
		move  = 1'b0;
		renew = 1'b0;
		if (state_q == S_SCAN) begin
			if (!sel_valid) begin
				move  = 1'b1;
				renew = 1'b1;
			end else if (hit || sel_lock) begin
				move = 1'b1;
			end
		end else if (state_q == S_EVICT) begin
			move  = 1'b1;
			renew = 1'b1;
		end
	end

	assign f_valid = renew | sel_valid;
	assign f_tag   = renew ? req_id_q : sel_tag;
	assign f_dirty = renew ? 1'b0 : sel_dirty;
	assign f_lock  = renew ? 1'b0 : sel_lock;

	assign slot_in_range = ({24'd0, slot} < 28'(SLOTS));
	assign flag_slot     = SLOT_W'(slot);
	assign ctl.set_flags = accept && (mode == lbpm_pkg::MODE_FLAGS) && slot_in_range;
	assign ctl.dirty     = dirty_value;
	assign ctl.lock      = lock_value;

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		logic ld;
		assign ld = move && (SLOT_W'(k) <= pos);
		if (k == 0) begin : g_front
			lbpm_cell #(
				.SLOT_W  (SLOT_W),
				.ID_BITS (ID_BITS),
				.POS     (k)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ld        (ld),
				.din_valid (f_valid),
				.din_slot  (sel_slot),
				.din_tag   (f_tag),
				.din_dirty (f_dirty),
				.din_lock  (f_lock),
				.ctl       (ctl),
				.flag_slot (flag_slot),
				.q_valid   (c_valid[k]),
				.q_slot    (c_slot[k]),
				.q_tag     (c_tag[k]),
				.q_dirty   (c_dirty[k]),
				.q_lock    (c_lock[k])
			);
		end else begin : g_rest
			lbpm_cell #(
				.SLOT_W  (SLOT_W),
				.ID_BITS (ID_BITS),
				.POS     (k)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ld        (ld),
				.din_valid (c_valid[k-1]),
				.din_slot  (c_slot[k-1]),
				.din_tag   (c_tag[k-1]),
				.din_dirty (c_dirty[k-1]),
				.din_lock  (c_lock[k-1]),
				.ctl       (ctl),
				.flag_slot (flag_slot),
				.q_valid   (c_valid[k]),
				.q_slot    (c_slot[k]),
				.q_tag     (c_tag[k]),
				.q_dirty   (c_dirty[k]),
				.q_lock    (c_lock[k])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cursor_q       <= '0;
			vpos_q         <= '0;
			have_victim_q  <= 1'b0;
			req_id_q       <= '0;
			req_get_q      <= 1'b0;
			res_status_q   <= lbpm_pkg::ST_NONE;
			res_index_q    <= '0;
			res_rd_q       <= 1'b0;
			res_wb_q       <= 1'b0;
			res_wb_block_q <= '0;
			out_valid_q    <= 1'b0;
			out_status_q   <= lbpm_pkg::ST_NONE;
			out_index_q    <= '0;
			out_rd_q       <= 1'b0;
			out_wb_q       <= 1'b0;
			out_wb_block_q <= '0;
		end else begin
			// S_OUT reloads the output register itself
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_id_q       <= block_id[ID_BITS-1:0];
						req_get_q      <= (mode == lbpm_pkg::MODE_GET);
						cursor_q       <= '0;
						have_victim_q  <= 1'b0;
						res_status_q   <= lbpm_pkg::ST_NONE;
						res_index_q    <= '0;
						res_rd_q       <= 1'b0;
						res_wb_q       <= 1'b0;
						res_wb_block_q <= '0;
						if (mode == lbpm_pkg::MODE_FLAGS) begin
							res_index_q <= slot;
							state_q     <= S_OUT;
						end else if ((mode == lbpm_pkg::MODE_GET || mode == lbpm_pkg::MODE_NEW)
							&& !block_id[ID_BITS]) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SCAN: begin
					// empty slots always sit at the tail in index order, so the
					// first empty position met holds the lowest empty slot
					if (!sel_valid) begin
						res_status_q <= lbpm_pkg::ST_FILL;
						res_index_q  <= lbpm_pkg::SLOT_IDX_W'(sel_slot);
						res_rd_q     <= req_get_q;
						state_q      <= S_OUT;
					end else if (hit) begin
						res_status_q <= lbpm_pkg::ST_HIT;
						res_index_q  <= lbpm_pkg::SLOT_IDX_W'(sel_slot);
						state_q      <= S_OUT;
					end else begin
						if (sel_lock) begin
							// locked slot jumps to the front, pushing the victim back one
							if (have_victim_q) begin
								vpos_q <= vpos_q + 1'b1;
							end
						end else begin
							vpos_q        <= cursor_q;
							have_victim_q <= 1'b1;
						end
						if (cursor_q == SLOT_W'(SLOTS - 1)) begin
							if (have_victim_q || !sel_lock) begin
								state_q <= S_EVICT;
							end else begin
								res_status_q <= lbpm_pkg::ST_LOCKED;
								res_index_q  <= '0;
								state_q      <= S_OUT;
							end
						end else begin
							cursor_q <= cursor_q + 1'b1;
						end
					end
				end
				S_EVICT: begin
					res_status_q   <= lbpm_pkg::ST_REPLACE;
					res_index_q    <= lbpm_pkg::SLOT_IDX_W'(sel_slot);
					res_rd_q       <= req_get_q;
					res_wb_q       <= sel_dirty;
					res_wb_block_q <= sel_dirty ? sel_tag : '0;
					state_q        <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q    <= 1'b1;
						out_status_q   <= res_status_q;
						out_index_q    <= res_index_q;
						out_rd_q       <= res_rd_q;
						out_wb_q       <= res_wb_q;
						out_wb_block_q <= res_wb_block_q;
						state_q        <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = out_status_q;
	assign slot_index        = out_index_q;
	assign read_needed       = out_rd_q;
	assign write_back_needed = out_wb_q;
	assign write_back_block  = out_wb_block_q;

endmodule

`default_nettype wire

### sim/lru_buffer_pool_manager_test.sv
`timescale 1ns / 1ps

module lru_buffer_pool_manager_test;

	localparam int SLOT_N = 16;
	localparam int ID_W = 20;
	localparam logic [lbpm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1600;
	localparam int CALM_WORDS = 200;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE = 30;
	localparam int HOT_IDS = 24;

	typedef struct {
		logic [lbpm_pkg::MODE_W-1:0]     mode;
		logic [ID_W:0]                   id;
		logic [lbpm_pkg::SLOT_IDX_W-1:0] slot;
		logic                            dirty;
		logic                            lock;
	} pool_req_t;

	typedef struct {
		logic [lbpm_pkg::STATUS_W-1:0]   status;
		logic [lbpm_pkg::SLOT_IDX_W-1:0] idx;
		logic                            rd;
		logic                            wb;
		logic [ID_W-1:0]                 wb_blk;
	} pool_resp_t;

	typedef struct {
		pool_req_t  req;
		bit         known;
		pool_resp_t resp;
	} script_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [lbpm_pkg::MODE_W-1:0]     mode = '0;
	logic [ID_W:0]                   block_id = '0;
	logic [lbpm_pkg::SLOT_IDX_W-1:0] slot = '0;
	logic                            dirty_value = 1'b0;
	logic                            lock_value = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [lbpm_pkg::STATUS_W-1:0]   status;
	logic [lbpm_pkg::SLOT_IDX_W-1:0] slot_index;
	logic                            read_needed;
	logic                            write_back_needed;
	logic [ID_W-1:0]                 write_back_block;

	// predicted pool contents
	int tag_of [SLOT_N];
	bit dirty_of [SLOT_N];
	bit lock_of [SLOT_N];
	int recency [SLOT_N];

	pool_resp_t      pending_results [$];
	logic [ID_W-1:0] hot_ids [HOT_IDS];
	int              mismatch_count = 0;
	bit              calm = 1'b0;
	bit              long_hold_req = 1'b0;

	lru_buffer_pool_manager #(
		.SLOTS(SLOT_N),
		.ID_BITS(ID_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.block_id(block_id),
		.slot(slot),
		.dirty_value(dirty_value),
		.lock_value(lock_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.slot_index(slot_index),
		.read_needed(read_needed),
		.write_back_needed(write_back_needed),
		.write_back_block(write_back_block)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic void promote(int pos);
		int s;
		s = recency[pos];
		for (int k = pos; k > 0; k--)
			recency[k] = recency[k - 1];
		recency[0] = s;
	endfunction

	function automatic int rank_of(int s);
		for (int k = 0; k < SLOT_N; k++)
			if (recency[k] == s)
				return k;
		return 0;
	endfunction

	function automatic pool_resp_t predict_request(pool_req_t rq);
		pool_resp_t r;
		int key, s, i, pick, victim;
		bit hit, empty_seen, have_victim;
		r.status = lbpm_pkg::ST_NONE;
		r.idx = '0;
		r.rd = 1'b0;
		r.wb = 1'b0;
		r.wb_blk = '0;
		key = int'(rq.id[ID_W-1:0]);
		hit = 1'b0;
		empty_seen = 1'b0;
		have_victim = 1'b0;
		victim = 0;
		pick = 0;
		if (rq.mode == lbpm_pkg::MODE_FLAGS) begin
			dirty_of[rq.slot] = rq.dirty;
			lock_of[rq.slot] = rq.lock;
			r.idx = rq.slot;
		end else if ((rq.mode == lbpm_pkg::MODE_GET || rq.mode == lbpm_pkg::MODE_NEW)
			&& !rq.id[ID_W]) begin
			i = 0;
			while (i < SLOT_N) begin
				s = recency[i];
				if (tag_of[s] < 0) begin
					empty_seen = 1'b1;
					break;
				end
				if (tag_of[s] == key) begin
					promote(i);
					hit = 1'b1;
					r.status = lbpm_pkg::ST_HIT;
					r.idx = s[lbpm_pkg::SLOT_IDX_W-1:0];
					break;
				end
				// locked slots passed on the walk jump to the front
				if (lock_of[s])
					promote(i);
				else begin
					victim = s;
					have_victim = 1'b1;
				end
				i++;
			end
			if (!hit) begin
				if (empty_seen) begin
					for (int k = SLOT_N - 1; k >= 0; k--)
						if (tag_of[k] < 0)
							pick = k;
					r.status = lbpm_pkg::ST_FILL;
				end else if (!have_victim) begin
					r.status = lbpm_pkg::ST_LOCKED;
				end else begin
					pick = victim;
					r.status = lbpm_pkg::ST_REPLACE;
					if (dirty_of[victim]) begin
						r.wb = 1'b1;
						r.wb_blk = tag_of[victim][ID_W-1:0];
					end
				end
				if (r.status != lbpm_pkg::ST_LOCKED) begin
					promote(rank_of(pick));
					tag_of[pick] = key;
					dirty_of[pick] = 1'b0;
					lock_of[pick] = 1'b0;
					r.idx = pick[lbpm_pkg::SLOT_IDX_W-1:0];
					r.rd = (rq.mode == lbpm_pkg::MODE_GET);
				end
			end
		end
		return r;
	endfunction

	function automatic script_row_t row(logic [lbpm_pkg::MODE_W-1:0] m, logic [ID_W:0] id,
			logic [lbpm_pkg::SLOT_IDX_W-1:0] sl, logic d, logic l, bit known,
			logic [lbpm_pkg::STATUS_W-1:0] st, logic [lbpm_pkg::SLOT_IDX_W-1:0] idx,
			logic rd, logic wb, logic [ID_W-1:0] wbb);
		script_row_t t;
		t.req.mode = m;
		t.req.id = id;
		t.req.slot = sl;
		t.req.dirty = d;
		t.req.lock = l;
		t.known = known;
		t.resp.status = st;
		t.resp.idx = idx;
		t.resp.rd = rd;
		t.resp.wb = wb;
		t.resp.wb_blk = wbb;
		return t;
	endfunction

	function automatic pool_req_t random_request();
		pool_req_t rq;
		logic [31:0] bits;
		int roll;
		bits = $urandom();
		rq.id = bits[ID_W:0];
		bits = $urandom();
		rq.slot = bits[lbpm_pkg::SLOT_IDX_W-1:0];
		rq.dirty = bits[8];
		rq.lock = bits[9];
		rq.mode = ($urandom_range(0, 1) == 0) ? lbpm_pkg::MODE_GET : lbpm_pkg::MODE_NEW;
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			rq.id[ID_W] = 1'b1;
			if (roll == 0)
				rq.id = '1;
		end else if (roll < 5) begin
			rq.mode = MODE_UNUSED;
		end else if (roll < 20) begin
			rq.mode = lbpm_pkg::MODE_FLAGS;
			rq.lock = ($urandom_range(0, 3) == 0);
		end else begin
			rq.id[ID_W] = 1'b0;
			// mostly a small working set so hits and evictions both happen
			if ($urandom_range(0, 6) != 0)
				rq.id[ID_W-1:0] = hot_ids[$urandom_range(0, HOT_IDS - 1)];
		end
		return rq;
	endfunction

	task automatic send_word(pool_req_t rq, bit known, pool_resp_t typed);
		pool_resp_t predicted;
		@(negedge clk);
		in_valid = 1'b1;
		mode = rq.mode;
		block_id = rq.id;
		slot = rq.slot;
		dirty_value = rq.dirty;
		lock_value = rq.lock;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = predict_request(rq);
		pending_results.push_back(known ? typed : predicted);
	endtask

	task automatic pause_sender(int n);
		@(negedge clk);
		in_valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// lock every slot, miss twice into the full locked pool and hit once, then release them again
	task automatic lock_sweep();
		pool_req_t rq;
		pool_resp_t blank;
		logic [31:0] bits;
		blank = '{default: '0};
		for (int s = 0; s < SLOT_N; s++) begin
			rq = random_request();
			rq.mode = lbpm_pkg::MODE_FLAGS;
			rq.slot = s[lbpm_pkg::SLOT_IDX_W-1:0];
			rq.lock = 1'b1;
			send_word(rq, 1'b0, blank);
		end
		for (int k = 0; k < 3; k++) begin
			bits = $urandom();
			rq.mode = (k == 1) ? lbpm_pkg::MODE_NEW : lbpm_pkg::MODE_GET;
			rq.id = {1'b0, bits[ID_W-1:0]};
			if (k == 2)
				rq.id = tag_of[$urandom_range(0, SLOT_N - 1)][ID_W:0];
			send_word(rq, 1'b0, blank);
		end
		for (int s = 0; s < SLOT_N; s++) begin
			rq = random_request();
			rq.mode = lbpm_pkg::MODE_FLAGS;
			rq.slot = s[lbpm_pkg::SLOT_IDX_W-1:0];
			rq.lock = 1'b0;
			send_word(rq, 1'b0, blank);
		end
	endtask

	initial begin : drain_side
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				out_ready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_hold_req = 1'b0;
			end else if (calm) begin
				out_ready = 1'b1;
			end else if ($urandom_range(0, 99) == 0) begin
				out_ready = 1'b1;
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end else if ($urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 9);
				out_ready = 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		pool_resp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word, status", status, 0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (slot_index !== want.idx)
					report_mismatch("slot_index", slot_index, want.idx);
				if (read_needed !== want.rd)
					report_mismatch("read_needed", read_needed, want.rd);
				if (write_back_needed !== want.wb)
					report_mismatch("write_back_needed", write_back_needed, want.wb);
				if (write_back_block !== want.wb_blk)
					report_mismatch("write_back_block", write_back_block, want.wb_blk);
			end
		end
	end

	initial begin : stimulus
		script_row_t rows [$];
		pool_resp_t blank;
		logic [31:0] bits;
		int gap_odds;
		blank = '{default: '0};
		gap_odds = 4;
		for (int s = 0; s < SLOT_N; s++) begin
			tag_of[s] = -1;
			dirty_of[s] = 1'b0;
			lock_of[s] = 1'b0;
			recency[s] = s;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		rows.push_back(row(lbpm_pkg::MODE_GET, 21'h000000, 0, 0, 0, 1,
			lbpm_pkg::ST_FILL, 0, 1, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_NEW, 21'h0FFFFF, 0, 0, 0, 1,
			lbpm_pkg::ST_FILL, 1, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_GET, 21'h1FFFFF, 7, 1, 1, 1,
			lbpm_pkg::ST_NONE, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_NEW, 21'h100000, 0, 0, 0, 1,
			lbpm_pkg::ST_NONE, 0, 0, 0, 0));
		rows.push_back(row(MODE_UNUSED, 21'h0ABCDE, 15, 1, 1, 1,
			lbpm_pkg::ST_NONE, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_GET, 21'h0FFFFF, 0, 0, 0, 1,
			lbpm_pkg::ST_HIT, 1, 0, 0, 0));
		// lock on a still empty slot: the later fill must clear it
		rows.push_back(row(lbpm_pkg::MODE_FLAGS, 21'h0, 15, 1, 1, 1,
			lbpm_pkg::ST_NONE, 15, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_FLAGS, 21'h0, 0, 1, 1, 1,
			lbpm_pkg::ST_NONE, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_GET, 21'h000000, 0, 0, 0, 1,
			lbpm_pkg::ST_HIT, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_FLAGS, 21'h0, 1, 1, 0, 1,
			lbpm_pkg::ST_NONE, 1, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_GET, 21'h055555, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_NEW, 21'h0AAAAA, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_GET, 21'h000001, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_NEW, 21'h080000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_GET, 21'h012345, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_NEW, 21'h0FEDCB, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_GET, 21'h000002, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_NEW, 21'h040000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_GET, 21'h00F0F0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_NEW, 21'h0F0F0F, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_GET, 21'h033333, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_NEW, 21'h0CCCCC, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_GET, 21'h07FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(row(lbpm_pkg::MODE_NEW, 21'h000010, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// pool full: slot 1 is least recent unlocked and dirty
		rows.push_back(row(lbpm_pkg::MODE_GET, 21'h054321, 0, 0, 0, 1,
			lbpm_pkg::ST_REPLACE, 1, 1, 1, 20'hFFFFF));

		foreach (rows[k])
			send_word(rows[k].req, rows[k].known, rows[k].resp);

		for (int k = 0; k < HOT_IDS; k++) begin
			bits = $urandom();
			hot_ids[k] = bits[ID_W-1:0];
		end

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 0 || n == 550 || n == 1100)
				lock_sweep();
			if (n % 50 == 49) begin
				bits = $urandom();
				hot_ids[$urandom_range(0, HOT_IDS - 1)] = bits[ID_W-1:0];
			end
			if (n % 100 == 0)
				gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 4;
			if (n == 300)
				long_hold_req = 1'b1;
			if (n == 750) begin
				pause_sender(1);
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			if (n == RANDOM_WORDS - CALM_WORDS)
				calm = 1'b1;
			send_word(random_request(), 1'b0, blank);
			if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
				pause_sender($urandom_range(1, 9));
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### files.f
rtl/lbpm_pkg.sv
rtl/lbpm_cell.sv
rtl/lru_buffer_pool_manager.sv
sim/lru_buffer_pool_manager_test.sv
